>>> rtl/core/tiu_pkg.sv
// shared types and constants of the trapezoid integrator unit
// no dependencies; used by every module of the block
package tiu_pkg;

  localparam int unsigned MAX_COUNT_DEF = 4096;
  localparam int unsigned F_W           = 25;   // integrand value, unsigned Q24
  localparam int unsigned DIV_STEPS     = 50;   // quotient bits of the ratio
  localparam int unsigned SQRT_STEPS    = 25;   // root bits

  // evaluator operand select
  localparam logic [1:0] EV_SEL_A = 2'd0;
  localparam logic [1:0] EV_SEL_B = 2'd1;
  localparam logic [1:0] EV_SEL_K = 2'd2;

  typedef struct packed {
    logic       load;
    logic       ev_start;
    logic [1:0] ev_sel;
    logic       acc;
    logic       dbl;
    logic       smul;
    logic       sadd;
    logic       mul0;
    logic       mul1;
    logic       fin;
  } ctrl_cmd_t;

  typedef struct packed {
    logic ev_done;
    logic k_lt_n;
  } ctrl_sts_t;

endpackage

>>> rtl/core/tiu_eval.sv
// iterative integrand unit: f(x) = sqrt((1+x^2)/(1+x^4)) in unsigned Q24
// depends on tiu_pkg
module tiu_eval import tiu_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic signed [31:0] x_i,
  output logic               done_o,
  output logic [F_W-1:0]     f_o
);

  localparam logic [2:0] P_IDLE = 3'd0;
  localparam logic [2:0] P_X4   = 3'd1;
  localparam logic [2:0] P_PREP = 3'd2;
  localparam logic [2:0] P_DIV  = 3'd3;
  localparam logic [2:0] P_SQRT = 3'd4;

  logic [2:0]       phase_q;
  logic [5:0]       cnt_q;
  logic             done_q;
  logic [62:0]      x2_q;
  logic [124:0]     acc_q;
  logic [124:0]     d_q;
  logic [124:0]     r_q;
  logic [DIV_STEPS-1:0] q_q;
  logic [27:0]      rem_q;
  logic [F_W-1:0]   root_q;

  logic [31:0]  ax;
  logic [63:0]  ax2;
  logic [31:0]  opa, opb;
  logic [63:0]  pp;
  logic [63:0]  num;
  logic [125:0] r2;
  logic         ge;
  logic [29:0]  remt, trial;
  logic         ge2;

  always_comb begin
    ax  = x_i[31] ? (~x_i + 32'd1) : x_i;
    ax2 = ax * ax;
    unique case (cnt_q[1:0])
      2'd0:    begin opa = x2_q[31:0]; opb = x2_q[31:0]; end
      2'd1:    begin opa = {1'b0, x2_q[62:32]}; opb = x2_q[31:0]; end
      default: begin opa = {1'b0, x2_q[62:32]}; opb = {1'b0, x2_q[62:32]}; end
    endcase
    pp    = opa * opb;
    num   = 64'(x2_q) + (64'd1 << 48);
    r2    = {r_q, 1'b0};
    ge    = r2 >= {1'b0, d_q};
    remt  = {rem_q, q_q[DIV_STEPS-1 -: 2]};
    trial = 30'({root_q, 2'b01});
    ge2   = remt >= trial;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= P_IDLE;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      unique case (phase_q)
        P_IDLE: begin
          if (start_i) begin
            phase_q <= P_X4;
            cnt_q   <= '0;
          end
        end
        P_X4: begin
          cnt_q <= cnt_q + 6'd1;
          if (cnt_q == 6'd2) phase_q <= P_PREP;
        end
        P_PREP: begin
          phase_q <= P_DIV;
          cnt_q   <= '0;
        end
        P_DIV: begin
          cnt_q <= cnt_q + 6'd1;
          if (cnt_q == 6'(DIV_STEPS - 1)) begin
            phase_q <= P_SQRT;
            cnt_q   <= '0;
          end
        end
        P_SQRT: begin
          cnt_q <= cnt_q + 6'd1;
          if (cnt_q == 6'(SQRT_STEPS - 1)) begin
            phase_q <= P_IDLE;
            done_q  <= 1'b1;
          end
        end
        default: phase_q <= P_IDLE;
      endcase
    end
  end

  // datapath of the evaluator
  always_ff @(posedge clk_i) begin
    unique case (phase_q)
      P_IDLE: if (start_i) x2_q <= ax2[62:0];
      P_X4: begin
        unique case (cnt_q[1:0])
          2'd0:    acc_q <= 125'(pp);
          2'd1:    acc_q <= acc_q + 125'({pp, 33'b0});
          default: acc_q <= acc_q + 125'({pp, 64'b0});
        endcase
      end
      P_PREP: begin
        d_q <= acc_q + (125'd1 << 96);
        r_q <= 125'({num, 46'b0});
      end
      P_DIV: begin
        r_q <= ge ? 125'(r2 - {1'b0, d_q}) : 125'(r2);
        q_q <= {q_q[DIV_STEPS-2:0], ge};
        if (cnt_q == 6'(DIV_STEPS - 1)) begin
          rem_q  <= '0;
          root_q <= '0;
        end
      end
      P_SQRT: begin
        rem_q  <= 28'(ge2 ? (remt - trial) : remt);
        root_q <= {root_q[F_W-2:0], ge2};
        q_q    <= {q_q[DIV_STEPS-3:0], 2'b00};
      end
      default: ;
    endcase
  end

  assign done_o = done_q;
  assign f_o    = root_q;

endmodule

>>> rtl/core/tiu_datapath.sv
// operand registers, sample generation, accumulation and final scaling
// depends on tiu_pkg and tiu_eval
module tiu_datapath import tiu_pkg::*; #(
  parameter int unsigned MAX_COUNT = MAX_COUNT_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ctrl_cmd_t          cmd_i,
  output ctrl_sts_t          sts_o,
  input  logic signed [31:0] lower_limit_i,
  input  logic signed [31:0] upper_limit_i,
  input  logic [12:0]        trapezoid_count_i,
  input  logic signed [31:0] step_width_i,
  output logic [47:0]        integral_estimate_o,
  output logic               done_o
);

  localparam int unsigned CNT_W = $clog2(MAX_COUNT + 1);
  localparam int unsigned SUM_W = CNT_W + F_W + 2;
  localparam int unsigned PK_W  = CNT_W + 33;
  localparam int unsigned XS_W  = CNT_W + 34;
  localparam logic signed [XS_W-1:0] XMAX = XS_W'(64'sd2147483647);
  localparam logic signed [XS_W-1:0] XMIN = XS_W'(-64'sd2147483648);

  logic signed [31:0] a_q, b_q, h_q, x_q;
  logic [CNT_W-1:0]   n_q, k_q;
  logic [SUM_W-1:0]   sum_q;
  logic signed [PK_W-1:0] pk_q;
  logic [95:0]        prod_q;
  logic [47:0]        res_q;
  logic               done_q;

  logic [31:0]        cnt_ext;
  logic [CNT_W-1:0]   n_d;
  logic signed [PK_W-1:0] pk_d;
  logic signed [XS_W-1:0] xs;
  logic signed [31:0] x_sat;
  logic signed [31:0] ev_x;
  logic               ev_done;
  logic [F_W-1:0]     f;
  logic [SUM_W-1:0]   f_add;
  logic [31:0]        habs;
  logic [63:0]        sum64;
  logic [63:0]        pp;
  logic [95:0]        rnd;
  logic [78:0]        mag;
  logic [47:0]        res_d;

  always_comb begin
    cnt_ext = 32'(trapezoid_count_i);
    n_d = (cnt_ext > 32'(MAX_COUNT)) ? CNT_W'(MAX_COUNT) : CNT_W'(cnt_ext);
    pk_d = $signed({1'b0, k_q}) * h_q;
    xs   = XS_W'(a_q) + XS_W'(pk_q);
    if (xs > XMAX)      x_sat = 32'sh7fff_ffff;
    else if (xs < XMIN) x_sat = 32'sh8000_0000;
    else                x_sat = xs[31:0];
    unique case (cmd_i.ev_sel)
      EV_SEL_A: ev_x = a_q;
      EV_SEL_B: ev_x = b_q;
      default:  ev_x = x_q;
    endcase
    f_add = cmd_i.dbl ? (SUM_W'(f) << 1) : SUM_W'(f);
    habs  = h_q[31] ? (~h_q + 32'd1) : h_q;
    sum64 = 64'(sum_q);
    pp    = (cmd_i.mul1 ? sum64[63:32] : sum64[31:0]) * habs;
    // round the Q49 magnitude to Q32, ties away from zero
    rnd   = prod_q + 96'(17'h1_0000);
    mag   = rnd[95:17];
    if (h_q[31]) begin
      res_d = (mag > 79'h8000_0000_0000) ? 48'h8000_0000_0000 : (48'd0 - mag[47:0]);
    end else begin
      res_d = (mag > 79'h7fff_ffff_ffff) ? 48'h7fff_ffff_ffff : mag[47:0];
    end
  end

  tiu_eval u_eval (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.ev_start),
    .x_i     (ev_x),
    .done_o  (ev_done),
    .f_o     (f)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      a_q   <= lower_limit_i;
      b_q   <= upper_limit_i;
      h_q   <= step_width_i;
      n_q   <= n_d;
      k_q   <= CNT_W'(1);
      sum_q <= '0;
    end
    if (cmd_i.acc && ev_done) begin
      sum_q <= sum_q + f_add;
      if (cmd_i.dbl) k_q <= k_q + CNT_W'(1);
    end
    if (cmd_i.smul) pk_q <= pk_d;
    if (cmd_i.sadd) x_q <= x_sat;
    if (cmd_i.mul0) prod_q <= 96'(pp);
    if (cmd_i.mul1) prod_q <= prod_q + {pp, 32'b0};
    if (cmd_i.fin)  res_q <= res_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= cmd_i.fin;
    end
  end

  assign sts_o.ev_done       = ev_done;
  assign sts_o.k_lt_n        = k_q < n_q;
  assign integral_estimate_o = res_q;
  assign done_o              = done_q;

endmodule

>>> rtl/core/tiu_ctrl.sv
// control state machine that sequences one integration request
// depends on tiu_pkg
module tiu_ctrl import tiu_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start,
  input  ctrl_sts_t sts_i,
  output ctrl_cmd_t cmd_o,
  output logic      busy
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_LDA  = 4'd1;
  localparam logic [3:0] S_WA   = 4'd2;
  localparam logic [3:0] S_LDB  = 4'd3;
  localparam logic [3:0] S_WB   = 4'd4;
  localparam logic [3:0] S_KCHK = 4'd5;
  localparam logic [3:0] S_SMUL = 4'd6;
  localparam logic [3:0] S_SADD = 4'd7;
  localparam logic [3:0] S_LDK  = 4'd8;
  localparam logic [3:0] S_WK   = 4'd9;
  localparam logic [3:0] S_MUL0 = 4'd10;
  localparam logic [3:0] S_MUL1 = 4'd11;
  localparam logic [3:0] S_FIN  = 4'd12;

  logic [3:0] state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          cmd_o.load = 1'b1;
          state_d    = S_LDA;
        end
      end
      S_LDA: begin
        cmd_o.ev_start = 1'b1;
        cmd_o.ev_sel   = EV_SEL_A;
        state_d        = S_WA;
      end
      S_WA: begin
        cmd_o.acc = 1'b1;
        if (sts_i.ev_done) state_d = S_LDB;
      end
      S_LDB: begin
        cmd_o.ev_start = 1'b1;
        cmd_o.ev_sel   = EV_SEL_B;
        state_d        = S_WB;
      end
      S_WB: begin
        cmd_o.acc = 1'b1;
        if (sts_i.ev_done) state_d = S_KCHK;
      end
      S_KCHK: state_d = sts_i.k_lt_n ? S_SMUL : S_MUL0;
      S_SMUL: begin
        cmd_o.smul = 1'b1;
        state_d    = S_SADD;
      end
      S_SADD: begin
        cmd_o.sadd = 1'b1;
        state_d    = S_LDK;
      end
      S_LDK: begin
        cmd_o.ev_start = 1'b1;
        cmd_o.ev_sel   = EV_SEL_K;
        state_d        = S_WK;
      end
      S_WK: begin
        cmd_o.acc = 1'b1;
        cmd_o.dbl = 1'b1;
        if (sts_i.ev_done) state_d = S_KCHK;
      end
      S_MUL0: begin
        cmd_o.mul0 = 1'b1;
        state_d    = S_MUL1;
      end
      S_MUL1: begin
        cmd_o.mul1 = 1'b1;
        state_d    = S_FIN;
      end
      S_FIN: begin
        cmd_o.fin = 1'b1;
        state_d   = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy = (state_q != S_IDLE);

endmodule

>>> rtl/core/trapezoid_integrator_unit.sv
// top level of the trapezoid integrator unit
// depends on tiu_pkg, tiu_ctrl, tiu_datapath (and tiu_eval below it)
//
// Estimates the integral of f(x) = sqrt((1+x^2)/(1+x^4)) by the trapezoidal
// rule. A request word (limits a and b, count n, step h, all Q8.24 except n)
// is taken when start is high and busy is low. Samples a + k*h are formed by
// multiplication and clamped to the Q8.24 range; n is clamped to MAX_COUNT.
// The result (Q16.32, rounded to nearest and saturating) appears on
// integral_estimate_o for exactly one cycle with done_o high; it cannot be
// held off, so the receiver must take it in that cycle. busy stays high from
// the accepted request until the cycle of done_o, and a new word can be taken
// in that cycle. An n of zero costs as much as an n of one. f(a), f(b) and
// every interior sample each run through a single shared iterative evaluator
// (three partial products for x^4, a 50-step restoring divider and a 25-step
// square root), so that unit sets the throughput; the final multiply and
// scaling follow in the states S_MUL0, S_MUL1 and S_FIN.
module trapezoid_integrator_unit import tiu_pkg::*; #(
  parameter int unsigned MAX_COUNT = MAX_COUNT_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic signed [31:0] lower_limit_i,
  input  logic signed [31:0] upper_limit_i,
  input  logic [12:0]        trapezoid_count_i,
  input  logic signed [31:0] step_width_i,
  output logic [47:0]        integral_estimate_o,
  output logic               done_o
);

  ctrl_cmd_t cmd;
  ctrl_sts_t sts;

  // sequencer: one request at a time
  tiu_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .sts_i  (sts),
    .cmd_o  (cmd),
    .busy   (busy)
  );

  // operands, sample generation, sum and final scaling
  tiu_datapath #(
    .MAX_COUNT (MAX_COUNT)
  ) u_dp (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cmd_i               (cmd),
    .sts_o               (sts),
    .lower_limit_i       (lower_limit_i),
    .upper_limit_i       (upper_limit_i),
    .trapezoid_count_i   (trapezoid_count_i),
    .step_width_i        (step_width_i),
    .integral_estimate_o (integral_estimate_o),
    .done_o              (done_o)
  );

`ifndef SYNTH
  // an accepted word keeps the unit busy in the next cycle
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy) else $error("busy not raised after accept");

  // a result word is a single-cycle pulse
  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("done_o longer than one cycle");

  // the result shows up as the unit returns to idle
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (!busy && $past(busy))) else $error("done_o while busy");
`endif

endmodule

>>> tb/sv/testbench.sv
// self-checking testbench of the trapezoid integrator unit
// depends on tiu_pkg and trapezoid_integrator_unit; holds its own integral predictor
module testbench;
  import tiu_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MAXN = MAX_COUNT_DEF;
  localparam int unsigned CALM_TAIL = 20;   // last words are sent back to back
  localparam longint ONE_Q24 = 64'sd16777216;

  // one request word
  typedef struct {
    logic signed [31:0] lo_lim;
    logic signed [31:0] hi_lim;
    logic [12:0]        count;
    logic signed [31:0] step;
  } request_t;

  logic               clk_i;
  logic               rst_ni;
  logic               start;
  logic               busy;
  logic signed [31:0] lower_limit_i;
  logic signed [31:0] upper_limit_i;
  logic [12:0]        trapezoid_count_i;
  logic signed [31:0] step_width_i;
  logic [47:0]        integral_estimate_o;
  logic               done_o;

  request_t    request_q[$];    // words waiting to be sent
  logic [47:0] estimate_q[$];   // predicted estimates, oldest first
  int unsigned num_sent;
  int unsigned num_checked;
  int unsigned num_errors;
  int unsigned num_total;
  int unsigned gap_cnt;

  trapezoid_integrator_unit u_dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .start              (start),
    .busy               (busy),
    .lower_limit_i      (lower_limit_i),
    .upper_limit_i      (upper_limit_i),
    .trapezoid_count_i  (trapezoid_count_i),
    .step_width_i       (step_width_i),
    .integral_estimate_o(integral_estimate_o),
    .done_o             (done_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // integer square root, bit by bit from the top
  function automatic logic [63:0] root64(input logic [63:0] v);
    logic [63:0] rem;
    logic [63:0] res;
    logic [63:0] probe;
    rem   = v;
    res   = '0;
    probe = 64'h4000_0000_0000_0000;
    while (probe > rem) probe = probe >> 2;
    while (probe != 0) begin
      if (rem >= res + probe) begin
        rem = rem - (res + probe);
        res = (res >> 1) + probe;
      end else begin
        res = res >> 1;
      end
      probe = probe >> 2;
    end
    return res;
  endfunction

  // f(x) = sqrt((1+x^2)/(1+x^4)) as unsigned Q24, x in Q8.24
  function automatic logic [63:0] curve_q24(input longint x);
    logic [63:0]  ax;
    logic [63:0]  sq;
    logic [159:0] numer;
    logic [159:0] denom;
    logic [159:0] ratio;
    ax    = (x < 0) ? 64'(-x) : 64'(x);
    sq    = ax * ax;
    numer = (160'(sq) + (160'd1 << 48)) << 96;
    denom = 160'(128'(sq) * 128'(sq)) + (160'd1 << 96);
    ratio = numer / denom;   // ratio scaled by 2^48
    return root64(ratio[63:0]);
  endfunction

  // sample a + k*h, clamped to the Q8.24 range
  function automatic longint sample_at(input longint a, input longint k, input longint h);
    longint s;
    s = a + k * h;
    if (s > 64'sd2147483647) s = 64'sd2147483647;
    if (s < -64'sd2147483648) s = -64'sd2147483648;
    return s;
  endfunction

  // trapezoidal estimate in signed Q16.32, rounded and saturating
  function automatic logic [47:0] predict_integral(input request_t rq);
    longint       a;
    longint       h;
    int unsigned  n;
    logic [63:0]  twice_sum;   // doubled sum, Q24
    logic [127:0] prod;
    logic [63:0]  mag;
    logic         neg;
    a   = longint'(rq.lo_lim);
    h   = longint'(rq.step);
    n   = rq.count;
    neg = (h < 0);
    if (n > MAXN) n = MAXN;
    twice_sum = curve_q24(a) + curve_q24(longint'(rq.hi_lim));
    for (int unsigned k = 1; k < n; k++)
      twice_sum += 2 * curve_q24(sample_at(a, longint'(k), h));
    prod = 128'(twice_sum) * 128'(neg ? 64'(-h) : 64'(h));
    prod = prod + (128'd1 << 16);
    // magnitude in Q32 with ties away from zero
    if (prod[127:81] != 0) mag = '1;
    else mag = prod[80:17];
    if (neg) begin
      if (mag > 64'h8000_0000_0000) mag = 64'h8000_0000_0000;
      mag = -mag;
    end else if (mag > 64'h7FFF_FFFF_FFFF) begin
      mag = 64'h7FFF_FFFF_FFFF;
    end
    return mag[47:0];
  endfunction

  // driver: a word is taken at an edge with start high and busy low
  always @(posedge clk_i or negedge rst_ni) begin
    request_t rq;
    logic     taken;
    if (!rst_ni) begin
      start             <= 1'b0;
      lower_limit_i     <= '0;
      upper_limit_i     <= '0;
      trapezoid_count_i <= '0;
      step_width_i      <= '0;
      gap_cnt           <= 0;
      num_sent          <= 0;
    end else begin
      taken = start && !busy;
      if (taken) begin
        rq.lo_lim = lower_limit_i;
        rq.hi_lim = upper_limit_i;
        rq.count  = trapezoid_count_i;
        rq.step   = step_width_i;
        estimate_q.push_back(predict_integral(rq));
        num_sent <= num_sent + 1;
      end
      // start changes only when no word is left pending at the port
      if (taken || !start) begin
        if (gap_cnt > 0) begin
          gap_cnt <= gap_cnt - 1;
          start   <= 1'b0;
        end else if (request_q.size() > 0) begin
          rq = request_q.pop_front();
          lower_limit_i     <= rq.lo_lim;
          upper_limit_i     <= rq.hi_lim;
          trapezoid_count_i <= rq.count;
          step_width_i      <= rq.step;
          start             <= 1'b1;
          // random idle bursts, none near the end of the run
          if (request_q.size() > CALM_TAIL && $urandom_range(0, 2) == 0)
            gap_cnt <= $urandom_range(1, 15);
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // monitor: every done_o cycle must match the oldest prediction
  always @(posedge clk_i) begin
    logic [47:0] want;
    if (rst_ni && done_o) begin
      if (estimate_q.size() == 0) begin
        $error("unexpected estimate %h with nothing pending", integral_estimate_o);
        num_errors++;
      end else begin
        want = estimate_q.pop_front();
        num_checked++;
        if (integral_estimate_o !== want) begin
          $error("integral_estimate: expected %h, actual %h", want, integral_estimate_o);
          num_errors++;
        end
      end
    end
  end

  function automatic request_t make_req(input longint a, input longint b,
                                        input int unsigned n, input longint h);
    request_t rq;
    rq.lo_lim = 32'(a);
    rq.hi_lim = 32'(b);
    rq.count  = 13'(n);
    rq.step   = 32'(h);
    return rq;
  endfunction

  // well-formed request: a in a few units, h = (b - a) / n
  function automatic request_t sane_req();
    longint      a;
    longint      b;
    int unsigned n;
    a = longint'($signed($urandom_range(0, 32'h0FFF_FFFF))) - 64'sd134217728;
    b = a + longint'($urandom_range(0, 32'h07FF_FFFF)) - 64'sd16777216;
    n = ($urandom_range(0, 7) == 0) ? $urandom_range(17, 64) : $urandom_range(1, 16);
    return make_req(a, b, n, (b - a) / longint'(n));
  endfunction

  initial begin
    request_t rq;
    num_checked = 0;
    num_errors  = 0;
    rst_ni = 1'b0;
    // directed words: field extremes, zero and clamped counts, signs of h
    request_q.push_back(make_req(0, ONE_Q24, 1, ONE_Q24));
    request_q.push_back(make_req(0, ONE_Q24, 0, ONE_Q24));
    request_q.push_back(make_req(0, 4 * ONE_Q24, 4, ONE_Q24));
    request_q.push_back(make_req(ONE_Q24, 0, 8, -ONE_Q24 / 8));
    request_q.push_back(make_req(-64'sd2147483648, 64'sd2147483647, 2, 64'sd2147483647));
    request_q.push_back(make_req(64'sd2147483647, -64'sd2147483648, 3, -64'sd2147483648));
    request_q.push_back(make_req(-64'sd2147483648, -64'sd2147483648, 1, -64'sd2147483648));
    request_q.push_back(make_req(64'sd2147483647, 64'sd2147483647, 1, 64'sd2147483647));
    // samples running past either end of the Q8.24 range
    request_q.push_back(make_req(120 * ONE_Q24, 0, 10, 4 * ONE_Q24));
    request_q.push_back(make_req(-120 * ONE_Q24, 0, 10, -4 * ONE_Q24));
    request_q.push_back(make_req(0, 0, 5, 0));
    request_q.push_back(make_req(0, 0, 1, 1));
    request_q.push_back(make_req(0, 0, 1, -1));
    request_q.push_back(make_req(-2 * ONE_Q24, 2 * ONE_Q24, 4096, ONE_Q24 / 1024));
    // count above the maximum, clamped; all count bits high
    request_q.push_back(make_req(-3 * ONE_Q24, 5 * ONE_Q24, 8191, ONE_Q24 / 512));
    request_q.push_back(make_req(ONE_Q24 / 2, -ONE_Q24 / 2, 4097 & 13'h1FFF, 64'sd7));
    // random part, mostly well-formed with some raw full-range words
    for (int i = 0; i < 124; i++) begin
      if ($urandom_range(0, 3) == 0) begin
        rq.lo_lim = $urandom();
        rq.hi_lim = $urandom();
        rq.step   = $urandom();
        rq.count  = 13'($urandom_range(0, 24));
      end else begin
        rq = sane_req();
      end
      request_q.push_back(rq);
    end
    num_total = request_q.size();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    // drain: everything sent and every estimate back
    while (request_q.size() > 0 || start || estimate_q.size() > 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    $display("testbench: %0d of %0d requests sent, %0d estimates compared",
             num_sent, num_total, num_checked);
    if (num_errors == 0 && estimate_q.size() == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

  // watchdog well beyond the slowest legal run
  initial begin
    #20000000;
    $display("testbench: done, errors");
    $finish;
  end

endmodule

>>> sim.f
rtl/core/tiu_pkg.sv
rtl/core/tiu_eval.sv
rtl/core/tiu_datapath.sv
rtl/core/tiu_ctrl.sv
rtl/core/trapezoid_integrator_unit.sv
tb/sv/testbench.sv
